// ===== design/lruwr_pkg.sv =====
// ----------------------------------------------------------------------------
// lruwr_pkg
// Shared types and constants for the true-LRU way replacement core.
// ----------------------------------------------------------------------------
package lruwr_pkg;

  localparam int WAYS    = 8;
  localparam int IDX_W   = $clog2(WAYS);
  localparam int AGE_W   = $clog2(WAYS);
  localparam int MASK_W  = 8;
  localparam int WAY_W   = 3;
  localparam int VWAY_W  = 4;
  localparam int RANK_W  = 3;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 8;

  typedef enum logic {
    MODE_VICTIM = 1'b0,
    MODE_ACCESS = 1'b1
  } mode_t;

  typedef logic [AGE_W-1:0] age_t;
  typedef age_t [WAYS-1:0] age_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0] previous_rank;
    logic              victim_found;
    logic [VWAY_W-1:0] victim_way;
  } res_t;

  // ways past the mask width count as valid and replaceable
  function automatic logic mask_bit(logic [MASK_W-1:0] m, int i);
    logic r;
    if (i >= MASK_W) begin
      r = 1'b1;
    end else begin
      r = m[i[$clog2(MASK_W)-1:0]];
    end
    return r;
  endfunction

endpackage

// ===== design/lruwr_select.sv =====
// ----------------------------------------------------------------------------
// lruwr_select
// Victim choice, recency update and rank lookup for one item.
// ----------------------------------------------------------------------------
module lruwr_select (
  input  lruwr_pkg::age_vec_t            ages,
  input  lruwr_pkg::mode_t               mode,
  input  logic [lruwr_pkg::WAY_W-1:0]    way,
  input  logic [lruwr_pkg::MASK_W-1:0]   valid_mask,
  input  logic [lruwr_pkg::MASK_W-1:0]   replaceable_mask,
  output lruwr_pkg::age_vec_t            ages_next,
  output lruwr_pkg::res_t                res
);

  logic                      found_inv;
  logic [lruwr_pkg::IDX_W-1:0] inv_idx;
  logic                      have_lru;
  logic [lruwr_pkg::IDX_W-1:0] lru_idx;
  lruwr_pkg::age_t           best;
  logic                      do_upd;
  logic                      way_ok;
  logic [lruwr_pkg::IDX_W-1:0] tgt;
  lruwr_pkg::age_t           old;

  always_comb begin
    found_inv = 1'b0;
    inv_idx   = '0;
    have_lru  = 1'b0;
    lru_idx   = '0;
    best      = '0;
    for (int i = 0; i < lruwr_pkg::WAYS; i++) begin
      if (!found_inv && !lruwr_pkg::mask_bit(valid_mask, i)) begin
        found_inv = 1'b1;
        inv_idx   = lruwr_pkg::IDX_W'(i);
      end
      if (lruwr_pkg::mask_bit(replaceable_mask, i) && (!have_lru || ages[i] > best)) begin
        have_lru = 1'b1;
        lru_idx  = lruwr_pkg::IDX_W'(i);
        best     = ages[i];
      end
    end

    way_ok = int'(way) < lruwr_pkg::WAYS;
    if (mode == lruwr_pkg::MODE_VICTIM) begin
      do_upd = found_inv || have_lru;
      tgt    = found_inv ? inv_idx : lru_idx;
    end else begin
      do_upd = way_ok;
      tgt    = lruwr_pkg::IDX_W'(way);
    end
    old = ages[tgt];

    for (int i = 0; i < lruwr_pkg::WAYS; i++) begin
      ages_next[i] = ages[i];
      if (do_upd) begin
        if (lruwr_pkg::IDX_W'(i) == tgt) begin
          ages_next[i] = '0;
        end else if (ages[i] < old) begin
          ages_next[i] = ages[i] + 1'b1;
        end
      end
    end

    res.victim_found  = (mode == lruwr_pkg::MODE_VICTIM) && do_upd;
    res.victim_way    = res.victim_found ? lruwr_pkg::VWAY_W'(tgt)
                                         : lruwr_pkg::VWAY_W'(lruwr_pkg::WAYS);
    res.previous_rank = (mode == lruwr_pkg::MODE_ACCESS && way_ok)
                        ? lruwr_pkg::RANK_W'(old) : '0;
  end

endmodule

// ===== design/lru_way_replacement_core.sv =====
// ----------------------------------------------------------------------------
// lru_way_replacement_core
// True-LRU recency order over the ways of one set: victim choice and hits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | tuser
//  s_*     | in  | way[2:0] valid_mask[7:0] replaceable_mask[7:0]| mode
//  m_*     | out | victim_way[3:0] victim_found previous_rank[2:0]| -
//
//  One item per cycle while m_tready is high: input register, decision logic, result register.
//  An item's result is valid once it moves into the result register and is
//  taken at a clock edge with m_tready high.
//  Recency ages update as the item moves into the result register, so the
//  next item always sees the order left by the previous one.
//  Reset restores the order way i = WAYS-1-i and empties both registers.
//  A stalled result holds the input register; s_tready stays high while the
//  input register is empty or moving on.
module lru_way_replacement_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lruwr_pkg::IN_W-1:0]    s_tdata,   // way, valid_mask, replaceable_mask
  input  logic                          s_tuser,   // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lruwr_pkg::OUT_W-1:0]   m_tdata    // victim_way, victim_found, previous_rank
);

  logic                          in_full;
  lruwr_pkg::mode_t              in_mode;
  logic [lruwr_pkg::WAY_W-1:0]   in_way;
  logic [lruwr_pkg::MASK_W-1:0]  in_valid;
  logic [lruwr_pkg::MASK_W-1:0]  in_repl;
  lruwr_pkg::age_vec_t           ages;
  lruwr_pkg::age_vec_t           ages_next;
  lruwr_pkg::res_t               res;
  lruwr_pkg::res_t               out_res;
  logic                          out_full;
  logic                          advance;

  assign advance  = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || advance;
  assign m_tvalid = out_full;
  assign m_tdata  = out_res;

  lruwr_select u_select (
    .ages             (ages),
    .mode             (in_mode),
    .way              (in_way),
    .valid_mask       (in_valid),
    .replaceable_mask (in_repl),
    .ages_next        (ages_next),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
      for (int i = 0; i < lruwr_pkg::WAYS; i++) begin
        ages[i] <= lruwr_pkg::AGE_W'(lruwr_pkg::WAYS - 1 - i);
      end
    end else begin
      if (s_tready) begin
        in_full <= s_tvalid;
      end
      if (advance) begin
        out_full <= 1'b1;
        ages     <= ages_next;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode  <= lruwr_pkg::mode_t'(s_tuser);
      in_way   <= s_tdata[lruwr_pkg::WAY_W-1:0];
      in_valid <= s_tdata[lruwr_pkg::WAY_W +: lruwr_pkg::MASK_W];
      in_repl  <= s_tdata[lruwr_pkg::WAY_W + lruwr_pkg::MASK_W +: lruwr_pkg::MASK_W];
    end
    if (advance) begin
      out_res <= res;
    end
  end

endmodule

// ===== design/lruwr_checker.sv =====
// ----------------------------------------------------------------------------
// lruwr_checker
// Port-level checks for the LRU way replacement core.
// ----------------------------------------------------------------------------
module lruwr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [lruwr_pkg::OUT_W-1:0]  m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_found_way: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3:0] != lruwr_pkg::VWAY_W'(lruwr_pkg::WAYS))
    else $error("victim found but way is none code");

  a_none_way: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == lruwr_pkg::VWAY_W'(lruwr_pkg::WAYS))
    else $error("no victim but way is not none code");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an open result side always lets the input move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while result side ready");

endmodule

bind lru_way_replacement_core lruwr_checker u_lruwr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
